// File: src/bcld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_pkg: shared constants for the biquad cascade level detector
// Register indexes, reset values, datapath widths and the sequencer taps.
// ----------------------------------------------------------------------------
package bcld_pkg;

	// largest supported block length
	localparam int MAX_BLOCK_DEF = 1024;

	// datapath widths
	localparam int SMP_W  = 16;
	localparam int COEF_W = 16;
	localparam int DAT_W  = 24;
	localparam int PROD_W = DAT_W + COEF_W;
	localparam int ACC_W  = 44;
	localparam int FRAC_W = 14;
	localparam int YW_W   = ACC_W - FRAC_W;
	localparam int CNT_W  = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_B0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LVL_TH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CNT_TH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLK_LEN = 3'd7;

	// register reset values
	localparam logic signed [COEF_W-1:0] B0_RST     = 16'sd1182;
	localparam logic signed [COEF_W-1:0] B1_RST     = 16'sd0;
	localparam logic signed [COEF_W-1:0] B2_RST     = -16'sd1182;
	localparam logic signed [COEF_W-1:0] A1_RST     = -16'sd30197;
	localparam logic signed [COEF_W-1:0] A2_RST     = 16'sd14020;
	localparam logic signed [DAT_W-1:0]  LVL_TH_RST = 24'sd20;
	localparam logic [CNT_W-1:0]         CNT_TH_RST = 11'd10;
	localparam logic [CNT_W-1:0]         BLK_LEN_RST = 11'd256;

	// multiply-accumulate taps of one section
	localparam logic [2:0] TAP_X  = 3'd0;
	localparam logic [2:0] TAP_X1 = 3'd1;
	localparam logic [2:0] TAP_X2 = 3'd2;
	localparam logic [2:0] TAP_Y1 = 3'd3;
	localparam logic [2:0] TAP_Y2 = 3'd4;

	// accumulator start value: half an LSB of the Q.14 result, for round half up
	localparam logic signed [ACC_W-1:0] ACC_INIT = 44'sd8192;

	// saturation limits
	localparam logic signed [YW_W-1:0]  YW_HI  = 30'sd8388607;
	localparam logic signed [YW_W-1:0]  YW_LO  = -30'sd8388608;
	localparam logic signed [DAT_W-1:0] SAT_HI = 24'sh7FFFFF;
	localparam logic signed [DAT_W-1:0] SAT_LO = 24'sh800000;

endpackage
`default_nettype wire

// File: src/biquad_cascade_level_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_cascade_level_detector: two-section biquad filter with level counter
// Filters each sample through two cascaded direct-form-I biquads, then
// counts samples above a level over blocks and flags detection per block.
// ----------------------------------------------------------------------------
// The block takes a new sample word only once it is through with the last
// one: a single 24x16 multiplier with a registered product feeds one 44-bit
// accumulator, and a small sequencer walks the five taps of section one,
// rounds and saturates, then does the same for section two.
// in_stall stays high during that walk; the result sits in an output
// register, so a new sample is taken while the previous result still waits
// on out_stall. The coefficient registers use Q2.14, and filter state
// persists across blocks. Write configuration only while no sample is in
// flight.
// ----------------------------------------------------------------------------
module biquad_cascade_level_detector #(
	parameter int MAX_BLOCK = bcld_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bcld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bcld_pkg::CFG_DATA_W-1:0]     cfg_data,
	// sample channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [bcld_pkg::SMP_W-1:0]   sample,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [bcld_pkg::DAT_W-1:0]        filtered,
	output logic                                     above_level,
	output logic                                     block_end,
	output logic [bcld_pkg::CNT_W-1:0]               block_count,
	output logic                                     detected
);
	import bcld_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCK);
	localparam int CMP_W = (IDX_W + 1 > CNT_W + 1) ? IDX_W + 1 : CNT_W + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MAC1 = 7'b0000010,
		S_DRN1 = 7'b0000100,
		S_SAT1 = 7'b0001000,
		S_MAC2 = 7'b0010000,
		S_DRN2 = 7'b0100000,
		S_SAT2 = 7'b1000000
	} state_t;

	// configuration registers
	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [DAT_W-1:0]  lvl_th_q;
	logic [CNT_W-1:0]         cnt_th_q;
	logic [CNT_W-1:0]         blk_len_q;

	// filter state
	logic signed [SMP_W-1:0]  in1_q, in2_q;
	logic signed [DAT_W-1:0]  mid1_q, mid2_q;
	logic signed [DAT_W-1:0]  out1_q, out2_q;
	logic [IDX_W-1:0]         idx_q;
	logic [CNT_W-1:0]         exceed_q;

	// sequencer and datapath
	state_t                   state_q;
	logic [2:0]               tap_q;
	logic signed [SMP_W-1:0]  x_q;
	logic signed [DAT_W-1:0]  mid_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     prod_vld_q;
	logic                     prod_sub_q;
	logic signed [ACC_W-1:0]  acc_q;

	// output register
	logic                     out_vld_q;
	logic signed [DAT_W-1:0]  filt_q;
	logic                     above_q;
	logic                     end_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     det_q;

	logic                     sect2;
	logic signed [DAT_W-1:0]  op_dat;
	logic signed [COEF_W-1:0] op_coef;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [YW_W-1:0]   y_wide;
	logic signed [DAT_W-1:0]  y_sat;
	logic                     above_c;
	logic [CNT_W-1:0]         cnt_c;
	logic [CMP_W-1:0]         len_raw;
	logic [CMP_W-1:0]         len_c;
	logic                     end_c;
	logic                     det_c;
	logic                     commit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	// configuration writes; bits above a register's width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q      <= B0_RST;
			b1_q      <= B1_RST;
			b2_q      <= B2_RST;
			a1_q      <= A1_RST;
			a2_q      <= A2_RST;
			lvl_th_q  <= LVL_TH_RST;
			cnt_th_q  <= CNT_TH_RST;
			blk_len_q <= BLK_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_B0:      b0_q      <= cfg_data[COEF_W-1:0];
				REG_B1:      b1_q      <= cfg_data[COEF_W-1:0];
				REG_B2:      b2_q      <= cfg_data[COEF_W-1:0];
				REG_A1:      a1_q      <= cfg_data[COEF_W-1:0];
				REG_A2:      a2_q      <= cfg_data[COEF_W-1:0];
				REG_LVL_TH:  lvl_th_q  <= cfg_data[DAT_W-1:0];
				REG_CNT_TH:  cnt_th_q  <= cfg_data[CNT_W-1:0];
				REG_BLK_LEN: blk_len_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	assign sect2 = (state_q == S_MAC2);

	always_comb begin
		op_dat  = '0;
		op_coef = '0;
		case (tap_q)
			TAP_X: begin
				op_dat  = sect2 ? mid_q : {{(DAT_W-SMP_W){x_q[SMP_W-1]}}, x_q};
				op_coef = b0_q;
			end
			TAP_X1: begin
				op_dat  = sect2 ? mid1_q : {{(DAT_W-SMP_W){in1_q[SMP_W-1]}}, in1_q};
				op_coef = b1_q;
			end
			TAP_X2: begin
				op_dat  = sect2 ? mid2_q : {{(DAT_W-SMP_W){in2_q[SMP_W-1]}}, in2_q};
				op_coef = b2_q;
			end
			TAP_Y1: begin
				op_dat  = sect2 ? out1_q : mid1_q;
				op_coef = a1_q;
			end
			TAP_Y2: begin
				op_dat  = sect2 ? out2_q : mid2_q;
				op_coef = a2_q;
			end
			default: begin
				op_dat  = '0;
				op_coef = '0;
			end
		endcase
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// floor of the Q.14 sum, then clamp to 24 bits
	assign y_wide = acc_q[ACC_W-1:FRAC_W];
	always_comb begin
		if (y_wide > YW_HI)
			y_sat = SAT_HI;
		else if (y_wide < YW_LO)
			y_sat = SAT_LO;
		else
			y_sat = y_wide[DAT_W-1:0];
	end

	// block bookkeeping, evaluated on the section two result
	assign above_c = (y_sat > lvl_th_q);
	assign cnt_c   = exceed_q + CNT_W'(above_c);

	always_comb begin
		len_raw = CMP_W'(blk_len_q);
		if (len_raw == '0)
			len_c = CMP_W'(1);
		else if (len_raw > CMP_W'(MAX_BLOCK))
			len_c = CMP_W'(MAX_BLOCK);
		else
			len_c = len_raw;
	end

	assign end_c  = (CMP_W'(idx_q) + CMP_W'(1)) >= len_c;
	assign det_c  = end_c && (cnt_c > cnt_th_q);
	assign commit = (state_q == S_SAT2) && (!out_vld_q || !out_stall);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tap_q      <= TAP_X;
			prod_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					prod_vld_q <= 1'b0;
					if (in_valid && !in_stall) begin
						tap_q   <= TAP_X;
						state_q <= S_MAC1;
					end
				end
				S_MAC1, S_MAC2: begin
					prod_vld_q <= 1'b1;
					if (tap_q == TAP_Y2)
						state_q <= sect2 ? S_DRN2 : S_DRN1;
					else
						tap_q <= tap_q + 3'd1;
				end
				S_DRN1: begin
					prod_vld_q <= 1'b0;
					state_q    <= S_SAT1;
				end
				S_SAT1: begin
					tap_q   <= TAP_X;
					state_q <= S_MAC2;
				end
				S_DRN2: begin
					prod_vld_q <= 1'b0;
					state_q    <= S_SAT2;
				end
				S_SAT2: begin
					// hold until the output register is free
					if (commit)
						state_q <= S_IDLE;
				end
				default: begin
					state_q    <= S_IDLE;
					prod_vld_q <= 1'b0;
				end
			endcase
		end
	end

	// multiplier and accumulator
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall)
			x_q <= sample;
		if (state_q == S_MAC1 || state_q == S_MAC2) begin
			prod_q     <= PROD_W'(op_dat) * PROD_W'(op_coef);
			prod_sub_q <= (tap_q >= TAP_Y1);
		end
		if (state_q == S_IDLE || state_q == S_SAT1)
			acc_q <= ACC_INIT;
		else if (prod_vld_q)
			acc_q <= prod_sub_q ? acc_q - prod_ext : acc_q + prod_ext;
		if (state_q == S_SAT1)
			mid_q <= y_sat;
	end

	// filter history and block counters advance once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in1_q    <= '0;
			in2_q    <= '0;
			mid1_q   <= '0;
			mid2_q   <= '0;
			out1_q   <= '0;
			out2_q   <= '0;
			idx_q    <= '0;
			exceed_q <= '0;
		end else if (commit) begin
			in2_q  <= in1_q;
			in1_q  <= x_q;
			mid2_q <= mid1_q;
			mid1_q <= mid_q;
			out2_q <= out1_q;
			out1_q <= y_sat;
			if (end_c) begin
				idx_q    <= '0;
				exceed_q <= '0;
			end else begin
				idx_q    <= idx_q + IDX_W'(1);
				exceed_q <= cnt_c;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (commit)
			out_vld_q <= 1'b1;
		else if (!out_stall)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			filt_q  <= y_sat;
			above_q <= above_c;
			end_q   <= end_c;
			cnt_q   <= cnt_c;
			det_q   <= det_c;
		end
	end

	assign out_valid   = out_vld_q;
	assign filtered    = filt_q;
	assign above_level = above_q;
	assign block_end   = end_q;
	assign block_count = cnt_q;
	assign detected    = det_q;

	// detection is only reported on the last word of a block
	a_det_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_end || !detected))
		else $error("detected set outside block end");

	// the tap counter never runs past the last tap while multiplying
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC1 || state_q == S_MAC2) |-> (tap_q <= TAP_Y2))
		else $error("tap counter out of range");

	// an accepted sample starts section one at its first tap
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MAC1 && tap_q == TAP_X))
		else $error("sample accepted without starting section one");

endmodule
`default_nettype wire

// File: dv/biquad_cascade_level_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_cascade_level_detector_tb: self-checking bench for the level detector
// Walks a short table of directed words and register writes, then runs random
// phases over several coefficient and block settings with sender gaps and
// receiver stalls. A behavioral copy of the two-section filter and the block
// counter predicts words with no table value; each is checked field by field.
// ----------------------------------------------------------------------------
module biquad_cascade_level_detector_tb;
	import bcld_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 20;
	localparam int DIR_ROWS = 35;
	localparam int NUM_PHASES = 9;

	typedef struct packed {
		logic signed [DAT_W-1:0] filtered;
		logic                    above;
		logic                    blk_end;
		logic [CNT_W-1:0]        count;
		logic                    det;
	} level_result_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		logic signed [SMP_W-1:0]  smp;
		logic                     typed;
		level_result_t            want;
	} dir_row_t;

	typedef enum logic [2:0] {SET_DEFAULT, SET_STABLE, SET_WILD, SET_MAX, SET_MIN} setting_kind_t;
	typedef enum logic [1:0] {ACT_NONE, ACT_LONG_HOLD, ACT_PAUSE, ACT_SHORTEN} phase_action_t;

	typedef struct packed {
		setting_kind_t kind;
		logic [6:0]    send_pct;
		logic [6:0]    stall_pct;
		logic [9:0]    items;
		phase_action_t action;
	} phase_t;

	localparam level_result_t NO_RES = '0;

	// writes come in runs, and the bench drains all results before each run
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sd0, 1'b1, '{24'sd0, 1'b0, 1'b0, 11'd0, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sd1, 1'b0, NO_RES},
		// unity gain with junk above the register width
		'{ROW_WRITE, REG_B0, 24'hAB4000, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_B1, 24'h000000, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_B2, 24'hFF0000, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_A1, 24'h550000, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_A2, 24'h000000, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_LVL_TH, 24'hFFFFFF, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_CNT_TH, 24'hFFF801, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_BLK_LEN, 24'h000803, 16'sd0, 1'b0, NO_RES},
		// block shortened below the current position: this word ends it
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b1, '{24'sd32767, 1'b1, 1'b0, 11'd1, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b1,
			'{24'shFF8000, 1'b0, 1'b0, 11'd1, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sd0, 1'b1, '{24'sd0, 1'b1, 1'b1, 11'd2, 1'b1}},
		'{ROW_SAMPLE, REG_B0, 24'h0, -16'sd1, 1'b1, '{-24'sd1, 1'b0, 1'b0, 11'd0, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, -16'sd2, 1'b1, '{-24'sd2, 1'b0, 1'b0, 11'd0, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, -16'sd1, 1'b1, '{-24'sd1, 1'b0, 1'b1, 11'd0, 1'b0}},
		// zero length acts as one
		'{ROW_WRITE, REG_BLK_LEN, 24'h000000, 16'sd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sd5, 1'b1, '{24'sd5, 1'b1, 1'b1, 11'd1, 1'b0}},
		'{ROW_SAMPLE, REG_B0, 24'h0, -16'sd5, 1'b1, '{-24'sd5, 1'b0, 1'b1, 11'd0, 1'b0}},
		// runaway feedback: drive both sections into saturation
		'{ROW_WRITE, REG_B0, 24'h007FFF, 16'sd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_A1, 24'h008000, 16'sd0, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh7FFF, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES},
		'{ROW_SAMPLE, REG_B0, 24'h0, 16'sh8000, 1'b0, NO_RES}
	};

	localparam phase_t PHASES [NUM_PHASES] = '{
		'{SET_DEFAULT, 7'd0, 7'd0, 10'd100, ACT_LONG_HOLD},
		'{SET_STABLE, 7'd73, 7'd0, 10'd90, ACT_NONE},
		'{SET_WILD, 7'd0, 7'd73, 10'd80, ACT_NONE},
		'{SET_STABLE, 7'd19, 7'd19, 10'd90, ACT_PAUSE},
		'{SET_MAX, 7'd0, 7'd0, 10'd70, ACT_SHORTEN},
		'{SET_MIN, 7'd19, 7'd19, 10'd50, ACT_NONE},
		'{SET_STABLE, 7'd0, 7'd73, 10'd90, ACT_NONE},
		'{SET_WILD, 7'd73, 7'd0, 10'd60, ACT_NONE},
		'{SET_DEFAULT, 7'd19, 7'd19, 10'd80, ACT_PAUSE}
	};

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [DAT_W-1:0] filtered;
	logic                    above_level;
	logic                    block_end;
	logic [CNT_W-1:0]        block_count;
	logic                    detected;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int mismatch_count = 0;
	level_result_t pending_levels[$];

	// filter and counter image
	logic signed [COEF_W-1:0] m_b0 = B0_RST;
	logic signed [COEF_W-1:0] m_b1 = B1_RST;
	logic signed [COEF_W-1:0] m_b2 = B2_RST;
	logic signed [COEF_W-1:0] m_a1 = A1_RST;
	logic signed [COEF_W-1:0] m_a2 = A2_RST;
	logic signed [DAT_W-1:0]  m_lvl = LVL_TH_RST;
	logic [CNT_W-1:0]         m_cth = CNT_TH_RST;
	logic [CNT_W-1:0]         m_blen = BLK_LEN_RST;
	logic signed [SMP_W-1:0]  in_h1 = '0, in_h2 = '0;
	logic signed [DAT_W-1:0]  mid_h1 = '0, mid_h2 = '0;
	logic signed [DAT_W-1:0]  out_h1 = '0, out_h2 = '0;
	logic [9:0]               blk_pos = '0;
	logic [CNT_W-1:0]         exceed_cnt = '0;

	biquad_cascade_level_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filtered    (filtered),
		.above_level (above_level),
		.block_end   (block_end),
		.block_count (block_count),
		.detected    (detected)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint biquad_section(input longint x, x1, x2, y1, y2);
		longint acc;
		longint y;
		acc = longint'(m_b0) * x + longint'(m_b1) * x1 + longint'(m_b2) * x2
			- longint'(m_a1) * y1 - longint'(m_a2) * y2;
		// round half up, then clamp to the 24-bit range
		y = (acc + 64'sd8192) >>> FRAC_W;
		if (y > longint'(SAT_HI))
			y = longint'(SAT_HI);
		if (y < longint'(SAT_LO))
			y = longint'(SAT_LO);
		return y;
	endfunction

	function automatic level_result_t filter_and_count(input logic signed [SMP_W-1:0] s);
		longint mid;
		longint y;
		int len;
		level_result_t r;
		mid = biquad_section(s, in_h1, in_h2, mid_h1, mid_h2);
		y = biquad_section(mid, mid_h1, mid_h2, out_h1, out_h2);
		in_h2 = in_h1;
		in_h1 = s;
		mid_h2 = mid_h1;
		mid_h1 = DAT_W'(mid);
		out_h2 = out_h1;
		out_h1 = DAT_W'(y);
		r.filtered = DAT_W'(y);
		r.above = y > longint'(m_lvl);
		if (r.above)
			exceed_cnt++;
		r.count = exceed_cnt;
		len = int'(m_blen);
		if (len == 0)
			len = 1;
		if (len > MAX_BLOCK_DEF)
			len = MAX_BLOCK_DEF;
		r.blk_end = int'(blk_pos) + 1 >= len;
		r.det = 1'b0;
		if (r.blk_end) begin
			r.det = exceed_cnt > m_cth;
			blk_pos = '0;
			exceed_cnt = '0;
		end else begin
			blk_pos++;
		end
		return r;
	endfunction

	function automatic logic signed [SMP_W-1:0] random_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return SMP_W'(int'($urandom_range(400)) - 200);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_level();
		level_result_t want;
		if (pending_levels.size() == 0) begin
			report_mismatch("unexpected result word, filtered", filtered, 'x);
		end else begin
			want = pending_levels.pop_front();
			if (filtered !== want.filtered)
				report_mismatch("filtered", filtered, want.filtered);
			if (above_level !== want.above)
				report_mismatch("above_level", above_level, want.above);
			if (block_end !== want.blk_end)
				report_mismatch("block_end", block_end, want.blk_end);
			if (block_count !== want.count)
				report_mismatch("block_count", block_count, want.count);
			if (detected !== want.det)
				report_mismatch("detected", detected, want.det);
		end
	endtask

	// starts after a rising edge, returns at the edge that accepts the word
	task automatic send_word(input logic signed [SMP_W-1:0] s, input logic typed,
			input level_result_t typed_want);
		level_result_t pred;
		@(negedge clk);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pred = filter_and_count(s);
		pending_levels.push_back(typed ? typed_want : pred);
	endtask

	// hold the sender until every expected word has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_B0:      m_b0 = data[COEF_W-1:0];
			REG_B1:      m_b1 = data[COEF_W-1:0];
			REG_B2:      m_b2 = data[COEF_W-1:0];
			REG_A1:      m_a1 = data[COEF_W-1:0];
			REG_A2:      m_a2 = data[COEF_W-1:0];
			REG_LVL_TH:  m_lvl = data[DAT_W-1:0];
			REG_CNT_TH:  m_cth = data[CNT_W-1:0];
			REG_BLK_LEN: m_blen = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_setting(input setting_kind_t kind);
		logic [CFG_DATA_W-1:0] b0, b1, b2, a1, a2, lvl, cth, blen;
		int a1v, a2v, bound;
		case (kind)
			SET_DEFAULT: begin
				b0 = {8'($urandom), B0_RST};
				b1 = {8'($urandom), B1_RST};
				b2 = {8'($urandom), B2_RST};
				a1 = {8'($urandom), A1_RST};
				a2 = {8'($urandom), A2_RST};
				lvl = CFG_DATA_W'($urandom_range(60));
				cth = CFG_DATA_W'($urandom_range(12));
				blen = CFG_DATA_W'($urandom_range(40, 4));
			end
			SET_STABLE: begin
				// keep the poles inside the unit circle
				a2v = int'($urandom_range(24000)) - 12000;
				bound = 16384 + a2v - 500;
				a1v = int'($urandom_range(2 * bound)) - bound;
				b0 = {8'($urandom), 16'(int'($urandom_range(32768)) - 16384)};
				b1 = {8'($urandom), 16'(int'($urandom_range(32768)) - 16384)};
				b2 = {8'($urandom), 16'(int'($urandom_range(32768)) - 16384)};
				a1 = {8'($urandom), 16'(a1v)};
				a2 = {8'($urandom), 16'(a2v)};
				lvl = CFG_DATA_W'(int'($urandom_range(4000)) - 2000);
				cth = CFG_DATA_W'($urandom_range(12));
				blen = CFG_DATA_W'($urandom_range(24, 1));
			end
			SET_WILD: begin
				b0 = CFG_DATA_W'($urandom);
				b1 = CFG_DATA_W'($urandom);
				b2 = CFG_DATA_W'($urandom);
				a1 = CFG_DATA_W'($urandom);
				a2 = CFG_DATA_W'($urandom);
				lvl = CFG_DATA_W'($urandom);
				cth = {13'($urandom), 11'($urandom_range(20))};
				blen = {13'($urandom), 11'($urandom_range(40, 1))};
			end
			SET_MAX: begin
				b0 = 24'h007FFF;
				b1 = 24'h007FFF;
				b2 = 24'h007FFF;
				a1 = 24'h007FFF;
				a2 = 24'h007FFF;
				lvl = 24'h7FFFFF;
				cth = 24'd1024;
				blen = 24'h0007FF;
			end
			default: begin
				b0 = 24'h008000;
				b1 = 24'h008000;
				b2 = 24'h008000;
				a1 = 24'h008000;
				a2 = 24'h008000;
				lvl = 24'h800000;
				cth = 24'd0;
				blen = 24'd0;
			end
		endcase
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_LVL_TH, lvl);
		write_reg(REG_CNT_TH, cth);
		write_reg(REG_BLK_LEN, blen);
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				compare_level();
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
					|| (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		dir_row_t row;
		phase_t ph;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_WRITE) begin
				if (i > 0 && DIRECTED[i-1].kind == ROW_SAMPLE)
					drain_results();
				write_reg(row.idx, row.data);
			end else begin
				send_word(row.smp, row.typed, row.want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			ph = PHASES[p];
			drain_results();
			send_idle_pct = int'(ph.send_pct);
			stall_pct = int'(ph.stall_pct);
			program_setting(ph.kind);
			for (int n = 0; n < int'(ph.items); n++) begin
				if (n == int'(ph.items) / 2) begin
					case (ph.action)
						ACT_LONG_HOLD: hold_request = 1'b1;
						ACT_PAUSE: drain_results();
						ACT_SHORTEN: begin
							// cut the block below the current position
							drain_results();
							write_reg(REG_BLK_LEN, CFG_DATA_W'($urandom_range(20, 1)));
						end
						default: ;
					endcase
				end
				send_word(random_sample(), 1'b0, NO_RES);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
